@@ rtl/emi2df_pkg.sv @@
// ----------------------------------------------------------------------------
// emi2df_pkg: shared types and constants of the frame deframer
// Holds the message codes, header positions and the result record that
// travels from the parser to the output buffer.
// ----------------------------------------------------------------------------
package emi2df_pkg;

  localparam logic [7:0] CodeDataInd = 8'h29;
  localparam logic [7:0] CodeBusMon  = 8'h2B;
  localparam logic [3:0] LenMask     = 4'hf;
  localparam logic [2:0] HopMask     = 3'h7;
  localparam logic [7:0] GroupBit    = 8'h80;

  localparam logic [7:0] PosCode     = 8'd0;
  localparam logic [7:0] PosCtrl1    = 8'd1;
  localparam logic [7:0] PosSrcHi    = 8'd2;
  localparam logic [7:0] PosSrcLo    = 8'd3;
  localparam logic [7:0] PosDstHi    = 8'd4;
  localparam logic [7:0] PosDstLo    = 8'd5;
  localparam logic [7:0] PosCtrl2    = 8'd6;
  localparam logic [7:0] PosDataBase = 8'd7;
  localparam logic [7:0] PosMonBase  = 8'd4;
  localparam logic [7:0] PosMax      = 8'd255;

  localparam int unsigned TdataW = 56;

  typedef struct packed {
    logic        last;
    logic [7:0]  idx;
    logic [7:0]  data;
    logic [2:0]  hop;
    logic        grp;
    logic [1:0]  prio;
    logic [15:0] dst;
    logic [15:0] src;
    logic        kind;
  } res_t;

endpackage

@@ rtl/emi2_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// emi2_frame_deframer: deframer for received bus-interface frames
// Frame bytes enter on the slave stream, one per transfer, with tlast on
// the final byte of each frame. Data indication frames give one result per
// payload byte, clamped to the declared length and carrying the header
// fields; bus monitor frames give every byte from the fifth one on.
// Other message codes and short frames give no result.
// A byte is taken into an input register, parsed from there and its result
// written to a two-entry output buffer, from which it is offered on the
// master stream; parsing waits while the buffer is full.
// One byte is accepted in every cycle as long as the output buffer has a
// free entry or the input register is empty; the parser sits between the
// input register and the output buffer and works one byte per cycle while
// the buffer has a free entry.
// When the receiver stalls, the buffer fills and the slave tready drops
// once both entries and the input register are occupied.
// Reset clears the byte position, the captured header and both stages.
// ----------------------------------------------------------------------------
module emi2_frame_deframer
  import emi2df_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // rx_byte[7:0]
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // source_addr[15:0], dest_addr[31:16], priority_class[33:32],
  // group_flag[34], hop_count[37:35], payload_byte[45:38],
  // payload_index[53:46], zero fill[55:54]
  output logic [TdataW-1:0] m_axis_tdata_o,
  // frame_kind
  output logic              m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       space;
  logic       step;
  logic       res_vld;
  res_t       res;
  res_t       out_res;

  assign step            = in_vld_q && space;
  assign s_axis_tready_o = !in_vld_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  emi2df_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  emi2df_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res_vld),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {2'b00, out_res.idx, out_res.data, out_res.hop, out_res.grp,
                           out_res.prio, out_res.dst, out_res.src};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last;

`ifndef SYNTHESIS
  a_push_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_vld) |=> m_axis_tvalid_o)
    else $error("Parsed result did not reach the output.");

  a_mon_no_hdr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[37:0] == 38'd0))
    else $error("Monitor result carries header fields.");

  a_data_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[53:50] == 4'd0))
    else $error("Data result index beyond the declared length range.");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && !space))
    else $error("Input stalled without a full pipeline.");
`endif

endmodule

@@ rtl/emi2df_parse.sv @@
// ----------------------------------------------------------------------------
// emi2df_parse: header capture and payload selection
// Tracks the byte position, captures the header fields and decides for each
// byte whether it leaves the block, together with its result fields.
// ----------------------------------------------------------------------------
module emi2df_parse
  import emi2df_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       res_vld_o,
  output res_t       res_o
);

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [1:0]  prio_q, prio_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        done_q, done_d;

  logic [7:0] data_idx;
  logic [7:0] mon_idx;
  logic       in_len;
  logic       len_end;
  logic       grp;

  always_comb begin
    code_d = code_q;
    prio_d = prio_q;
    src_d  = src_q;
    dst_d  = dst_q;
    ctrl_d = ctrl_q;
    unique case (pos_q)
      PosCode:  code_d       = byte_i;
      PosCtrl1: prio_d       = byte_i[3:2];
      PosSrcHi: src_d[15:8]  = byte_i;
      PosSrcLo: src_d[7:0]   = byte_i;
      PosDstHi: dst_d[15:8]  = byte_i;
      PosDstLo: dst_d[7:0]   = byte_i;
      PosCtrl2: ctrl_d       = byte_i;
      default: ;
    endcase
  end

  assign data_idx = pos_q - PosDataBase;
  assign mon_idx  = pos_q - PosMonBase;
  assign in_len   = (data_idx[7:4] == 4'h0) && (data_idx[3:0] <= (ctrl_q[3:0] & LenMask));
  assign len_end  = data_idx[3:0] == (ctrl_q[3:0] & LenMask);
  assign grp      = (ctrl_q & GroupBit) != 8'h00;

  always_comb begin
    res_vld_o = 1'b0;
    res_o     = '0;
    done_d    = done_q;
    if ((code_q == CodeDataInd) && (pos_q >= PosDataBase) && !done_q) begin
      if (in_len) begin
        res_vld_o   = 1'b1;
        res_o.kind  = 1'b0;
        res_o.src   = src_q;
        res_o.dst   = grp ? dst_q : 16'h0000;
        res_o.prio  = prio_q;
        res_o.grp   = grp;
        res_o.hop   = ctrl_q[6:4] & HopMask;
        res_o.data  = byte_i;
        res_o.idx   = data_idx;
        res_o.last  = last_i || len_end;
        if (last_i || len_end) begin
          done_d = 1'b1;
        end
      end
    end else if ((code_q == CodeBusMon) && (pos_q >= PosMonBase)) begin
      res_vld_o  = 1'b1;
      res_o.kind = 1'b1;
      res_o.data = byte_i;
      res_o.idx  = mon_idx;
      res_o.last = last_i;
    end
    if (last_i) begin
      pos_d  = '0;
      done_d = 1'b0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 8'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      code_q <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      prio_q <= '0;
      ctrl_q <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      code_q <= code_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      prio_q <= prio_d;
      ctrl_q <= ctrl_d;
      done_q <= done_d;
    end
  end

endmodule

@@ rtl/emi2df_obuf.sv @@
// ----------------------------------------------------------------------------
// emi2df_obuf: two-entry result buffer
// Holds finished results so that the parser keeps running for one more
// transfer while the receiver stalls.
// ----------------------------------------------------------------------------
module emi2df_obuf
  import emi2df_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
